[rtl/kwe_pkg.sv]
// kwe_pkg: shared types, widths and constants of the k-mer window extractor.
// Holds the base decode function and the result record.
// No dependencies.
package kwe_pkg;

    // Field widths
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned POS_W    = 28;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned CODE_W   = 64;
    localparam int unsigned COORD_W  = 30;
    localparam int unsigned OFF_W    = 11;
    localparam int unsigned RUN_W    = 6;
    localparam int unsigned MAX_K    = 32;

    // ASCII nucleotide characters
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    // 2-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_dec_t;

    typedef struct packed {
        logic [OFF_W-1:0]   variant_offset;
        logic [COORD_W-1:0] window_end;
        logic [COORD_W-1:0] window_start;
        logic [CODE_W-1:0]  kmer_code;
    } kmer_res_t;

    // Case-insensitive ACGT decode; anything else breaks the run
    function automatic base_dec_t base_decode(input logic [CHAR_W-1:0] ch);
        base_dec_t d;
        d.ok   = 1'b1;
        d.code = CODE_A;
        case (ch)
            CHAR_A_UP, CHAR_A_LO: d.code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: d.code = CODE_C;
            CHAR_G_UP, CHAR_G_LO: d.code = CODE_G;
            CHAR_T_UP, CHAR_T_LO: d.code = CODE_T;
            default:              d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[rtl/kwe_track.sv]
// kwe_track: sequence state (code shift line, run, index, anchor), length
// register and the combinational window result. Depends on kwe_pkg.
module kwe_track #(
    parameter int unsigned MAX_SEQ_LEN = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [kwe_pkg::LEN_W-1:0]         cfg_data,
    input  logic                              in_accept,
    input  logic [kwe_pkg::CHAR_W-1:0]        base_char,
    input  logic                              first_base,
    input  logic [kwe_pkg::POS_W-1:0]         variant_position,
    output logic                              res_valid,
    output kwe_pkg::kmer_res_t                res
);

    localparam int unsigned IDX_W = $clog2(MAX_SEQ_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SEQ_LEN);

    logic [kwe_pkg::LEN_W-1:0]  kmer_length_reg;
    logic [kwe_pkg::CODE_W-1:0] code_shift_reg, code_shift_next;
    logic [kwe_pkg::RUN_W-1:0]  valid_run_reg, valid_run_next;
    logic [IDX_W-1:0]           base_index_reg, base_index_next;
    logic [kwe_pkg::POS_W-1:0]  anchor_reg, anchor_next;

    logic [kwe_pkg::LEN_W-1:0]  k_eff;
    logic [kwe_pkg::RUN_W-1:0]  run_base;
    logic [IDX_W-1:0]           idx_base;
    logic                       in_range;
    kwe_pkg::base_dec_t         dec;
    logic [kwe_pkg::CODE_W-1:0] k_mask;
    logic [kwe_pkg::COORD_W-1:0] cur_ext, two_k, start_w;
    logic                       emit;

    // Length register, reset 21
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= kwe_pkg::LEN_W'(21);
        end else if (cfg_valid) begin
            kmer_length_reg <= cfg_data;
        end
    end

    // Clamp k to 1..32
    always_comb begin
        if (kmer_length_reg == '0) begin
            k_eff = kwe_pkg::LEN_W'(1);
        end else if (kmer_length_reg > kwe_pkg::LEN_W'(kwe_pkg::MAX_K)) begin
            k_eff = kwe_pkg::LEN_W'(kwe_pkg::MAX_K);
        end else begin
            k_eff = kmer_length_reg;
        end
    end

    // Window mask, one 2-bit lane per base
    always_comb begin
        for (int i = 0; i < kwe_pkg::MAX_K; i++) begin
            k_mask[2*i +: 2] = (6'(i) < k_eff) ? 2'b11 : 2'b00;
        end
    end

    // Next state and result for one item
    always_comb begin
        dec      = kwe_pkg::base_decode(base_char);
        run_base = first_base ? '0 : valid_run_reg;
        idx_base = first_base ? '0 : base_index_reg;
        in_range = (idx_base < IDX_MAX);

        code_shift_next = code_shift_reg;
        valid_run_next  = run_base;
        base_index_next = idx_base;
        anchor_next     = first_base ? variant_position : anchor_reg;
        emit            = 1'b0;

        if (in_range) begin
            base_index_next = idx_base + IDX_W'(1);
            if (dec.ok) begin
                code_shift_next = {code_shift_reg[kwe_pkg::CODE_W-3:0], dec.code};
                if (run_base < kwe_pkg::RUN_W'(kwe_pkg::MAX_K)) begin
                    valid_run_next = run_base + kwe_pkg::RUN_W'(1);
                end
                emit = (valid_run_next >= k_eff);
            end else begin
                valid_run_next = '0;
            end
        end

        // Coordinates, wrapped to the field widths
        cur_ext = kwe_pkg::COORD_W'(idx_base);
        two_k   = kwe_pkg::COORD_W'({k_eff, 1'b0});
        start_w = kwe_pkg::COORD_W'(anchor_next) + cur_ext
                  + kwe_pkg::COORD_W'(1) - two_k;

        res.kmer_code      = code_shift_next & k_mask;
        res.window_start   = start_w;
        res.window_end     = start_w + kwe_pkg::COORD_W'(k_eff);
        res.variant_offset = kwe_pkg::OFF_W'(two_k - kwe_pkg::COORD_W'(1) - cur_ext);
        res_valid          = in_accept && emit;
    end

    // State update on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_shift_reg <= '0;
            valid_run_reg  <= '0;
            base_index_reg <= '0;
            anchor_reg     <= '0;
        end else if (in_accept) begin
            code_shift_reg <= code_shift_next;
            valid_run_reg  <= valid_run_next;
            base_index_reg <= base_index_next;
            anchor_reg     <= anchor_next;
        end
    end

    // Run saturates at the shift line depth
    a_run_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_run_reg <= kwe_pkg::RUN_W'(kwe_pkg::MAX_K))
        else $error("valid run beyond 32");

    // Index never passes the sequence limit
    a_idx_max: assert property (@(posedge aclk) disable iff (!aresetn)
        base_index_reg <= IDX_MAX)
        else $error("base index beyond limit");

    // A sequence start leaves the index at one at most
    a_first_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && first_base) |=> (base_index_reg <= IDX_W'(1)))
        else $error("index not restarted");

    // A result always has a run of at least k behind it
    a_emit_run: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (valid_run_reg >= $past(k_eff)))
        else $error("result without a full run");

endmodule

[rtl/kwe_out_reg.sv]
// kwe_out_reg: result holding register between window logic and the
// master stream side. Depends on kwe_pkg.
module kwe_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_load,
    input  kwe_pkg::kmer_res_t in_res,
    output logic               up_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output kwe_pkg::kmer_res_t out_res
);

    logic               valid_reg, valid_next;
    kwe_pkg::kmer_res_t res_reg;

    // Free when empty or draining this cycle
    assign up_ready   = !valid_reg || out_ready;
    assign valid_next = (valid_reg && !out_ready) || in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_load) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Loads only into a free register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        in_load |-> (!valid_reg || out_ready))
        else $error("result overwritten");

    // A load is shown on the next cycle
    a_load_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        in_load |=> valid_reg)
        else $error("loaded result lost");

    // Without a load, a taken result leaves the register empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && out_ready && !in_load) |=> !valid_reg)
        else $error("result repeated");

endmodule

[rtl/kmer_window_extractor.sv]
// kmer_window_extractor: top level of the k-mer window extractor.
// Uses kwe_pkg, kwe_track and kwe_out_reg.
//
// Usage:
//   One nucleotide byte per s_ transfer. s_tuser high starts a new sequence
//   and latches variant_position as the anchor. Each ACGT byte (either case)
//   extends the valid run; any other byte breaks it. Once the run holds k
//   bases, a result with the packed k-mer and its coordinates appears on m_.
//   cfg_valid/cfg_data write kmer_length (k); the user writes it only while
//   the block is idle, not enforced by the block. cfg_ready is always high.
//   A result is on m_ in the cycle after the input transfer that causes it.
//   Throughput: one item per cycle, set by the single result register, while
//   it is empty or being drained; the sequence state updates in the same cycle.
//   Reset: state, anchor and run clear, k returns to 21, m_tvalid drops.
//   Stall: s_tready follows m_tready while a result is held, so an item is
//   taken whenever the result register is empty or being drained.
//   Bytes beyond MAX_SEQ_LEN in one sequence are taken and dropped.
module kmer_window_extractor #(
    parameter int unsigned MAX_SEQ_LEN = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Length register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // base_char[7:0], variant_position[35:8], zero fill
    input  logic         s_tuser,   // first_base
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // kmer_code[63:0], window_start[93:64],
                                    // window_end[123:94], variant_offset[134:124]
);

    logic               in_accept;
    logic               res_valid;
    kwe_pkg::kmer_res_t res;
    kwe_pkg::kmer_res_t out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Sequence state and window result
    kwe_track #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_track (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .in_accept        (in_accept),
        .base_char        (s_tdata[7:0]),
        .first_base       (s_tuser),
        .variant_position (s_tdata[35:8]),
        .res_valid        (res_valid),
        .res              (res)
    );

    // Result register
    kwe_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_load   (res_valid),
        .in_res    (res),
        .up_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res};

endmodule

[test/kmer_window_extractor_test.sv]
`timescale 1ns / 100ps
// kmer_window_extractor_test: self-checking bench for the k-mer window extractor.
// A tracker class predicts every window from the accepted base transfers and checks
// each result transfer against it. Depends on kwe_pkg and the extractor RTL.

class kmer_window_tracker;
    logic [5:0]         length_reg;
    logic [63:0]        code_hist;
    int unsigned        run_len;
    int unsigned        next_index;
    logic [27:0]        anchor;
    int unsigned        seq_limit;
    kwe_pkg::kmer_res_t window_q[$];
    int unsigned        fault_count;

    function new(int unsigned max_len);
        seq_limit   = max_len;
        length_reg  = 6'd21;
        code_hist   = '0;
        run_len     = 0;
        next_index  = 0;
        anchor      = '0;
        fault_count = 0;
    endfunction

    function void set_length(logic [5:0] len);
        length_reg = len;
    endfunction

    function int unsigned pending();
        return window_q.size();
    endfunction

    // Advance the sequence state by one accepted base; queue a window if one completes
    function void take_base(logic [7:0] ch, logic is_first, logic [27:0] pos);
        int                 k;
        int                 cur;
        int                 start_pos;
        int                 end_pos;
        int                 offset;
        logic [1:0]         code;
        logic               valid;
        logic [63:0]        mask;
        kwe_pkg::kmer_res_t win;

        // zero acts as one, anything above 32 as 32
        k = (length_reg == 0) ? 1 : (length_reg > 32) ? 32 : int'(length_reg);
        if (is_first) begin
            run_len    = 0;
            next_index = 0;
            anchor     = pos;
        end
        // past the sequence limit: dropped without any effect
        if (next_index >= seq_limit)
            return;
        cur = next_index;
        next_index++;

        valid = 1'b1;
        code  = kwe_pkg::CODE_A;
        case (ch)
            kwe_pkg::CHAR_A_UP, kwe_pkg::CHAR_A_LO: code = kwe_pkg::CODE_A;
            kwe_pkg::CHAR_C_UP, kwe_pkg::CHAR_C_LO: code = kwe_pkg::CODE_C;
            kwe_pkg::CHAR_G_UP, kwe_pkg::CHAR_G_LO: code = kwe_pkg::CODE_G;
            kwe_pkg::CHAR_T_UP, kwe_pkg::CHAR_T_LO: code = kwe_pkg::CODE_T;
            default:                                valid = 1'b0;
        endcase
        // degenerate or foreign byte: run breaks, history kept
        if (!valid) begin
            run_len = 0;
            return;
        end
        code_hist = {code_hist[61:0], code};
        if (run_len < 32)
            run_len++;
        if (run_len < k)
            return;

        mask      = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        start_pos = int'(anchor) + cur + 1 - 2 * k;
        end_pos   = start_pos + k;
        offset    = 2 * k - 1 - cur;
        win.kmer_code      = code_hist & mask;
        win.window_start   = start_pos[29:0];
        win.window_end     = end_pos[29:0];
        win.variant_offset = offset[10:0];
        window_q = {window_q, win};
    endfunction

    // Compare one result transfer with the oldest predicted window
    function void match_window(kwe_pkg::kmer_res_t got);
        kwe_pkg::kmer_res_t want;

        if (window_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: unexpected window code=%h start=%h end=%h off=%h", $time,
                         got.kmer_code, got.window_start, got.window_end, got.variant_offset);
            return;
        end
        want = window_q.pop_front();
        if (got.kmer_code !== want.kmer_code || got.window_start !== want.window_start ||
            got.window_end !== want.window_end ||
            got.variant_offset !== want.variant_offset) begin
            fault_count++;
            if (fault_count <= 10) begin
                $display("%0t: window mismatch", $time);
                $display("  expected code=%h start=%h end=%h off=%h", want.kmer_code,
                         want.window_start, want.window_end, want.variant_offset);
                $display("  actual   code=%h start=%h end=%h off=%h", got.kmer_code,
                         got.window_start, got.window_end, got.variant_offset);
            end
        end
    endfunction
endclass

module kmer_window_extractor_test;
    localparam int unsigned SEQ_MAX       = 1024;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 36;
    localparam int unsigned PHASES        = 12;
    localparam int unsigned LONG_SEQ      = 1030;
    localparam logic [8*4-1:0]  ACGT_CHARS  = "ACGT";
    localparam logic [8*11-1:0] IUPAC_CHARS = "RYSWKMBDHVN";
    localparam logic [7:0]      LOWER_BIT   = 8'h20;

    // k per phase; the first is written at the end of the directed part
    localparam logic [5:0] PHASE_LEN [PHASES] =
        '{6'd63, 6'd32, 6'd2, 6'd0, 6'd1, 6'd40, 6'd17, 6'd31, 6'd33, 6'd8, 6'd21, 6'd5};

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [5:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;   // base_char[7:0], variant_position[35:8], zero fill
    logic         s_tuser  = 1'b0; // first_base
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;         // kmer_code[63:0], window_start[93:64],
                                   // window_end[123:94], variant_offset[134:124]

    int unsigned  send_gap_pct = 11;
    int unsigned  recv_gap_pct = 78;
    bit           hold_request = 1'b0;
    int unsigned  hold_left    = 0;
    int unsigned  items_sent   = 0;
    int unsigned  quiet_cycles = 0;

    kmer_window_tracker tracker = new(SEQ_MAX);

    kmer_window_extractor #(
        .MAX_SEQ_LEN(SEQ_MAX)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Observe both streams at the rising edge; input side first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.take_base(s_tdata[7:0], s_tuser, s_tdata[35:8]);
            if (m_tvalid && m_tready)
                tracker.match_window(m_tdata[134:0]);
        end
    end

    // Watchdog: too many cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("kmer_window_extractor test failed");
            $finish;
        end
    end

    // Result side: random back-pressure plus an occasional long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    function automatic logic [7:0] pick_base();
        return ACGT_CHARS[8 * $urandom_range(3) +: 8] | ($urandom_range(1) ? LOWER_BIT : 8'h00);
    endfunction

    // Degenerate letters in either case, or any byte at all
    function automatic logic [7:0] pick_junk();
        if ($urandom_range(2) == 2)
            return 8'($urandom_range(255));
        return IUPAC_CHARS[8 * $urandom_range(10) +: 8] | ($urandom_range(1) ? LOWER_BIT : 8'h00);
    endfunction

    // One base transfer, with random idle cycles ahead of it
    task automatic send_base(input logic [7:0] ch, input logic is_first, input logic [27:0] pos);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pos, ch};
        s_tuser  <= is_first;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait for every predicted window to come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input logic [5:0] len);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        tracker.set_length(len);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // New sequence of the given length, junk bytes mixed in at junk_pct percent
    task automatic run_sequence(input int unsigned len, input int unsigned junk_pct);
        for (int i = 0; i < len; i++)
            send_base(($urandom_range(99) < junk_pct) ? pick_junk() : pick_base(),
                      i == 0, 28'($urandom));
    endtask

    // Stimulus
    initial begin
        int unsigned phase_start;
        int unsigned seq_no;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Bases before any start flag belong to a sequence anchored at zero
        send_base("a", 1'b0, 28'h0);
        send_base("C", 1'b0, 28'hFFFFFFF);
        send_base("g", 1'b0, 28'h0);
        drain_results();
        write_length(6'd1);
        send_base("t", 1'b0, 28'h0);
        drain_results();

        // Length zero acts as one; every letter in both cases, junk bytes
        write_length(6'd0);
        send_base("A", 1'b1, 28'hFFFFFFF);
        send_base("c", 1'b0, 28'h0);
        send_base("G", 1'b0, 28'h0);
        send_base("t", 1'b0, 28'h0);
        send_base("T", 1'b0, 28'h0);
        send_base("g", 1'b0, 28'h0);
        send_base("C", 1'b0, 28'h0);
        send_base("a", 1'b0, 28'h0);
        send_base(8'h00, 1'b0, 28'h0);
        send_base(8'hFF, 1'b0, 28'hFFFFFFF);
        send_base("N", 1'b0, 28'h0);
        send_base("r", 1'b0, 28'h0);
        send_base("B", 1'b0, 28'h0);
        send_base("G", 1'b0, 28'h0);
        send_base("A", 1'b1, 28'h0);
        send_base("t", 1'b0, 28'h0);
        drain_results();
        write_length(PHASE_LEN[0]);

        // Random phases, one length each
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES / 3) begin
                send_gap_pct = 78;
                recv_gap_pct = 11;
            end else if (p == 2 * PHASES / 3) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            // continue the open sequence under the new length
            repeat (4) send_base(pick_base(), 1'b0, 28'($urandom));

            phase_start = items_sent;
            seq_no      = 0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == 9 && seq_no == 0)
                    hold_request = 1'b1;
                if (p == 10 && seq_no == 2)
                    drain_results();
                if ($urandom_range(3) == 0)
                    run_sequence($urandom_range(1, 12), 50);
                else
                    run_sequence($urandom_range(1, 48), 3);
                seq_no++;
            end

            // one sequence that runs past the length limit
            if (p == 4)
                run_sequence(LONG_SEQ, 2);

            drain_results();
            if (p + 1 < PHASES)
                write_length(PHASE_LEN[p + 1]);
        end

        drain_results();
        if (tracker.fault_count == 0 && tracker.pending() == 0)
            $display("kmer_window_extractor test passed");
        else
            $display("kmer_window_extractor test failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/kwe_pkg.sv
rtl/kwe_track.sv
rtl/kwe_out_reg.sv
rtl/kmer_window_extractor.sv
test/kmer_window_extractor_test.sv
